FILE: hw/rtl/sab_pkg.sv
// Shared types and constants for the spike adaptation bank
`timescale 1ns / 1ps

package sab_pkg;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 24;
  localparam int DECAY_W = 16;
  localparam int BUMP_W  = 20;
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = VAL_W + GAIN_W;
  localparam int ADDR_W  = 4;

  typedef logic [VAL_W-1:0]   value_t;
  typedef logic [IDX_W-1:0]   index_t;
  typedef logic [PROD_W-1:0]  prod_t;

  typedef logic [1:0] reg_sel_t;

  localparam reg_sel_t REG_DECAY = 2'd0;
  localparam reg_sel_t REG_BUMP  = 2'd1;
  localparam reg_sel_t REG_GAIN  = 2'd2;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'hFFFF;
  localparam logic [BUMP_W-1:0]  BUMP_RESET  = 20'h10000;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'h0100;

  localparam value_t VALUE_MAX = 24'hFFFFFF;

endpackage

FILE: hw/rtl/spike_adaptation_bank.sv
// Spike adaptation bank: per-neuron adaptation store with read-modify-write pipeline
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+------------------------------
//   request  | neuron_index, fired                 | taken when start && !busy
//   result   | neuron_echo, hyperpol_mv            | done high for one cycle
//   config   | psel penable pwrite paddr pwdata    | write when psel&penable&pwrite
//
// One request per cycle while busy is low; done is registered from the s1 stage that the accepting edge loads.
// The store is one memory with a registered read; the update of the
// preceding request is forwarded from a write-back register.
// After reset busy stays high while the store is swept to zero.
// The result side cannot stall; busy is high only during the clearing sweep.
`timescale 1ns / 1ps

module spike_adaptation_bank #(
  parameter int NEURONS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [sab_pkg::IDX_W-1:0]          neuron_index,
  input  logic                               fired,
  output logic                               done,
  output logic [sab_pkg::IDX_W-1:0]          neuron_echo,
  output logic [sab_pkg::VAL_W-1:0]          hyperpol_mv,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sab_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int FULL  = 1 << sab_pkg::IDX_W;
  localparam int DEPTH = (NEURONS < FULL) ? NEURONS : FULL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [sab_pkg::DECAY_W-1:0] decay_factor;
  logic [sab_pkg::BUMP_W-1:0]  bump_amount;
  logic [sab_pkg::GAIN_W-1:0]  gain;

  logic                wr_en;
  sab_pkg::reg_sel_t   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor <= sab_pkg::DECAY_RESET;
      bump_amount  <= sab_pkg::BUMP_RESET;
      gain         <= sab_pkg::GAIN_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        sab_pkg::REG_DECAY: decay_factor <= pwdata[sab_pkg::DECAY_W-1:0];
        sab_pkg::REG_BUMP:  bump_amount  <= pwdata[sab_pkg::BUMP_W-1:0];
        sab_pkg::REG_GAIN:  gain         <= pwdata[sab_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      sab_pkg::REG_DECAY: prdata = 32'(decay_factor);
      sab_pkg::REG_BUMP:  prdata = 32'(bump_amount);
      sab_pkg::REG_GAIN:  prdata = 32'(gain);
      default:            prdata = 32'd0;
    endcase
  end

  // clearing sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // request stage
  logic          accept;
  logic          in_range;
  logic [AW-1:0] raddr;

  assign accept   = start && !busy;
  assign in_range = 32'(neuron_index) < NEURONS;
  assign raddr    = neuron_index[AW-1:0];

  logic                 s1_valid;
  logic                 s1_inr;
  logic                 s1_fired;
  logic [AW-1:0]        s1_addr;
  sab_pkg::index_t      s1_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_inr   <= in_range;
    s1_fired <= fired;
    s1_addr  <= raddr;
    s1_idx   <= neuron_index;
  end

  // store
  sab_pkg::value_t mem [DEPTH];
  sab_pkg::value_t rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  sab_pkg::value_t mem_wdata;
  sab_pkg::value_t new_value;

  assign mem_we    = clearing || (s1_valid && s1_inr);
  assign mem_waddr = clearing ? clr_addr : s1_addr;
  assign mem_wdata = clearing ? '0 : new_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  // forward the previous write-back
  logic            fwd_valid;
  logic [AW-1:0]   fwd_addr;
  sab_pkg::value_t fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_valid && s1_inr;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1_addr;
    fwd_data <= new_value;
  end

  // update
  sab_pkg::value_t         cur;
  sab_pkg::prod_t          drive_prod;
  sab_pkg::prod_t          decay_prod;
  logic [sab_pkg::VAL_W:0] next_sum;
  sab_pkg::value_t         drive;

  always_comb begin
    cur        = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;
    drive_prod = sab_pkg::PROD_W'(gain) * sab_pkg::PROD_W'(cur);
    decay_prod = sab_pkg::PROD_W'(decay_factor) * sab_pkg::PROD_W'(cur);
    next_sum   = {1'b0, decay_prod[sab_pkg::PROD_W-1:sab_pkg::FRAC_W]};
    if (s1_fired) begin
      next_sum = next_sum + (sab_pkg::VAL_W+1)'(bump_amount);
    end
    new_value  = next_sum[sab_pkg::VAL_W] ? sab_pkg::VALUE_MAX
                                          : next_sum[sab_pkg::VAL_W-1:0];
    drive      = s1_inr ? drive_prod[sab_pkg::PROD_W-1:sab_pkg::FRAC_W] : '0;
  end

  // result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    neuron_echo <= s1_idx;
    hyperpol_mv <= drive;
  end

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without a request two cycles earlier");

  a_sweep_ends_at_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(clr_addr) == AW'(DEPTH - 1))
    else $error("clearing sweep ended early");

  a_fwd_from_write: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> $past(mem_we && !clearing))
    else $error("forward register set without a write-back");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_inr) |=> (done && hyperpol_mv == '0))
    else $error("out-of-range neuron gave a non-zero drive");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for spike_adaptation_bank: directed and random requests checked against a predictor
module tb;

  localparam sab_pkg::reg_sel_t REG_NONE = 2'd3;

  typedef struct {
    sab_pkg::index_t idx;
    logic            fired;
    logic            drain;
  } step_req_t;

  typedef struct {
    sab_pkg::index_t echo;
    sab_pkg::value_t drive;
  } drive_res_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  sab_pkg::index_t            neuron_index = '0;
  logic                       fired = 1'b0;
  logic                       done;
  sab_pkg::index_t            neuron_echo;
  sab_pkg::value_t            hyperpol_mv;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [sab_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  sab_pkg::value_t               adapt_mem [0:1023];
  logic [sab_pkg::DECAY_W-1:0]   cur_decay = sab_pkg::DECAY_RESET;
  logic [sab_pkg::BUMP_W-1:0]    cur_bump = sab_pkg::BUMP_RESET;
  logic [sab_pkg::GAIN_W-1:0]    cur_gain = sab_pkg::GAIN_RESET;
  step_req_t                     step_q[$];
  drive_res_t                    drive_q[$];
  int                            sender_idle_pct = 7;
  int                            fail_count = 0;

  spike_adaptation_bank #(.NEURONS(1024)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .neuron_index(neuron_index), .fired(fired),
    .done(done), .neuron_echo(neuron_echo), .hyperpol_mv(hyperpol_mv),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic drive_res_t adapt_update(input sab_pkg::index_t idx, input logic spk);
    logic [sab_pkg::PROD_W-1:0] prod;
    logic [sab_pkg::PROD_W:0]   next_val;
    drive_res_t                 res;
    prod = cur_gain * adapt_mem[idx];
    res.echo = idx;
    res.drive = ((prod >> sab_pkg::FRAC_W) > sab_pkg::VALUE_MAX) ? sab_pkg::VALUE_MAX
                                                              : prod[sab_pkg::FRAC_W +: sab_pkg::VAL_W];
    prod = adapt_mem[idx] * cur_decay;
    next_val = (prod >> sab_pkg::FRAC_W) + (spk ? cur_bump : '0);
    adapt_mem[idx] = (next_val > sab_pkg::VALUE_MAX) ? sab_pkg::VALUE_MAX
                                                     : next_val[sab_pkg::VAL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    step_req_t nxt;
    logic      go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = 1'b0;
      if (start && !busy) drive_q.push_back(adapt_update(neuron_index, fired));
      if (!start || !busy) begin
        if (step_q.size() > 0 && step_q[0].drain) begin
          if (drive_q.size() == 0) void'(step_q.pop_front());
        end else if (step_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = step_q.pop_front();
          go = 1'b1;
          neuron_index <= nxt.idx;
          fired <= nxt.fired;
        end
        if (!go) begin
          neuron_index <= sab_pkg::index_t'($urandom);
          fired <= 1'($urandom);
        end
        start <= go;
      end
    end
  end

  always @(posedge clk) begin
    drive_res_t exp_r;
    if (!rst && done) begin
      if (drive_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, echo %0d drive %0d", $time, neuron_echo,
                 hyperpol_mv);
      end else begin
        exp_r = drive_q.pop_front();
        if (neuron_echo !== exp_r.echo) begin
          fail_count++;
          $display("%0t: neuron_echo expected %0d actual %0d", $time, exp_r.echo,
                   neuron_echo);
        end
        if (hyperpol_mv !== exp_r.drive) begin
          fail_count++;
          $display("%0t: hyperpol_mv (neuron %0d) expected %0d actual %0d", $time,
                   exp_r.echo, exp_r.drive, hyperpol_mv);
        end
      end
    end
  end

  task automatic add_step(input sab_pkg::index_t idx, input logic spk);
    step_q.push_back('{idx: idx, fired: spk, drain: 1'b0});
  endtask

  task automatic add_drain();
    step_q.push_back('{idx: '0, fired: 1'b0, drain: 1'b1});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (step_q.size() > 0 || start || drive_q.size() > 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input sab_pkg::reg_sel_t sel,
                          input logic [31:0] data, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    rdata = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input sab_pkg::reg_sel_t sel, input logic [31:0] data);
    logic [31:0] rd;
    logic [31:0] want;
    logic [31:0] mask;
    apb_xfer(1'b1, sel, data, rd);
    case (sel)
      sab_pkg::REG_DECAY: cur_decay = data[sab_pkg::DECAY_W-1:0];
      sab_pkg::REG_BUMP:  cur_bump = data[sab_pkg::BUMP_W-1:0];
      sab_pkg::REG_GAIN:  cur_gain = data[sab_pkg::GAIN_W-1:0];
      default: ;
    endcase
    if (sel != REG_NONE) begin
      apb_xfer(1'b0, sel, '0, rd);
      case (sel)
        sab_pkg::REG_DECAY: begin
          want = 32'(cur_decay);
          mask = (32'd1 << sab_pkg::DECAY_W) - 1;
        end
        sab_pkg::REG_BUMP: begin
          want = 32'(cur_bump);
          mask = (32'd1 << sab_pkg::BUMP_W) - 1;
        end
        default: begin
          want = 32'(cur_gain);
          mask = (32'd1 << sab_pkg::GAIN_W) - 1;
        end
      endcase
      if ((rd & mask) !== want) begin
        fail_count++;
        $display("%0t: prdata (register %0d) expected %0d actual %0d", $time, sel, want,
                 rd & mask);
      end
    end
  endtask

  task automatic set_config(input int decay, input int bump, input int gn);
    wait_idle();
    write_reg(sab_pkg::REG_DECAY, {16'($urandom), 16'(decay)});
    write_reg(sab_pkg::REG_BUMP, {12'($urandom), 20'(bump)});
    write_reg(sab_pkg::REG_GAIN, {16'($urandom), 16'(gn)});
  endtask

  task automatic random_burst(input int n);
    sab_pkg::index_t hot [8];
    sab_pkg::index_t idx;
    int              r;
    int              fire_pct;
    idx = '0;
    fire_pct = $urandom_range(90, 10);
    foreach (hot[k]) hot[k] = sab_pkg::index_t'($urandom);
    hot[0] = $urandom_range(1) ? '0 : '1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) == 0) add_drain();
      r = $urandom_range(99);
      if (r < 60) idx = hot[$urandom_range(7)];
      else if (r >= 75) idx = sab_pkg::index_t'($urandom);
      add_step(idx, $urandom_range(99) < fire_pct);
    end
  endtask

  initial begin
    foreach (adapt_mem[k]) adapt_mem[k] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // back-to-back hits on one neuron exercise the write-back forwarding
    add_step(10'd0, 1'b1);
    add_step(10'd0, 1'b1);
    add_step(10'd0, 1'b1);
    add_step(10'd0, 1'b0);
    add_step(10'd1023, 1'b1);
    add_step(10'd1023, 1'b0);
    add_step(10'd1023, 1'b0);
    add_step(10'd1, 1'b1);
    add_step(10'd0, 1'b1);
    add_step(10'd1, 1'b0);
    add_step(10'd0, 1'b0);
    add_step(10'd512, 1'b1);
    add_drain();
    add_step(10'd512, 1'b1);
    add_step(10'd511, 1'b0);

    set_config(0, 1048575, 65535);
    add_step(10'd5, 1'b1);
    add_step(10'd5, 1'b1);
    add_step(10'd5, 1'b0);
    set_config(65535, 0, 0);
    add_step(10'd5, 1'b0);
    add_step(10'd5, 1'b1);
    add_step(10'd1023, 1'b0);

    wait_idle();
    write_reg(REG_NONE, $urandom);
    random_burst(275);

    set_config(65535, 1048575, 65535);
    random_burst(275);

    set_config(0, $urandom_range(1048575), $urandom_range(65535));
    sender_idle_pct = 61;
    random_burst(275);

    set_config($urandom_range(65535), 0, 0);
    write_reg(REG_NONE, $urandom);
    random_burst(275);

    set_config($urandom_range(65535), $urandom_range(1048575), $urandom_range(65535));
    sender_idle_pct = 0;
    random_burst(275);

    set_config($urandom_range(65535, 65000), $urandom_range(4095), $urandom_range(65535));
    random_burst(275);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
